// ===== src/ecl_pkg.sv =====
package ecl_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int IN_W         = 32;
  localparam int TOTAL_W      = 64;
  localparam int COUNT_W      = 32;
  localparam int LEN_W        = $clog2(VALUE_WIDTH + 2);
  localparam int CODE_W       = LEN_W + 2;
  localparam int OMEGA_PASSES = 8;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [LEN_W-1:0] blen;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // bit length of a small value; zero counts as one bit
  function automatic logic [LEN_W-1:0] small_len(input logic [LEN_W-1:0] m);
    logic [LEN_W-1:0] r;
    r = LEN_W'(1);
    for (int i = 0; i < LEN_W; i++) begin
      if (m[i]) r = LEN_W'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] gamma_len(input logic [LEN_W-1:0] blen);
    return CODE_W'({blen, 1'b0}) - CODE_W'(1);
  endfunction

  function automatic logic [CODE_W-1:0] delta_len(input logic [LEN_W-1:0] blen);
    logic [LEN_W-1:0] lb;
    lb = small_len(blen);
    return CODE_W'({lb, 1'b0}) - CODE_W'(1) + CODE_W'(blen) - CODE_W'(1);
  endfunction

  // first pass uses the value's own bit length, later passes work on small numbers
  function automatic logic [CODE_W-1:0] omega_len(input logic [LEN_W-1:0] blen);
    logic [CODE_W-1:0] tot;
    logic [LEN_W-1:0]  m;
    logic [LEN_W-1:0]  len;
    tot = CODE_W'(1);
    m   = '0;
    if (blen > LEN_W'(1)) begin
      tot = tot + CODE_W'(blen);
      m   = blen - LEN_W'(1);
    end
    for (int p = 1; p < OMEGA_PASSES; p++) begin
      if (m > LEN_W'(1)) begin
        len = small_len(m);
        tot = tot + CODE_W'(len);
        m   = len - LEN_W'(1);
      end
    end
    return tot;
  endfunction

endpackage

// ===== src/ecl_in_if.sv =====
interface ecl_in_if;
  logic                       valid;
  logic                       ready;
  logic [ecl_pkg::IN_W-1:0]   value;
  logic                       last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// ===== src/ecl_out_if.sv =====
interface ecl_out_if;
  logic                          valid;
  logic                          ready;
  logic [ecl_pkg::TOTAL_W-1:0]   gamma_bits;
  logic [ecl_pkg::TOTAL_W-1:0]   delta_bits;
  logic [ecl_pkg::TOTAL_W-1:0]   omega_bits;
  logic [ecl_pkg::COUNT_W-1:0]   value_count;

  modport source (output valid, gamma_bits, delta_bits, omega_bits, value_count,
                  input ready);
  modport sink   (input valid, gamma_bits, delta_bits, omega_bits, value_count,
                  output ready);
endinterface

// ===== src/ecl_front.sv =====
module ecl_front (
  ecl_in_if.sink                in_item,
  input  ecl_pkg::q_status_t    stat,
  output logic                  push,
  output ecl_pkg::q_entry_t     entry
);

  logic [63:0]                      vx;
  logic [ecl_pkg::VALUE_WIDTH:0]    n;
  logic [ecl_pkg::LEN_W-1:0]        blen;

  assign in_item.ready = !stat.full;
  assign push          = in_item.valid && in_item.ready;

  always_comb begin
    vx   = 64'(in_item.value);
    n    = {1'b0, vx[ecl_pkg::VALUE_WIDTH-1:0]} + (ecl_pkg::VALUE_WIDTH + 1)'(1);
    blen = ecl_pkg::LEN_W'(1);
    for (int i = 0; i <= ecl_pkg::VALUE_WIDTH; i++) begin
      if (n[i]) blen = ecl_pkg::LEN_W'(i + 1);
    end
    entry.blen = blen;
    entry.last = in_item.last;
  end

endmodule

// ===== src/ecl_fifo.sv =====
module ecl_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ecl_pkg::q_entry_t     wr_data,
  input  logic                  pop,
  output ecl_pkg::q_entry_t     rd_data,
  output ecl_pkg::q_status_t    stat
);

  ecl_pkg::q_entry_t              mem [ecl_pkg::QDEPTH];
  logic [ecl_pkg::QPTR_W-1:0]     wptr;
  logic [ecl_pkg::QPTR_W-1:0]     rptr;
  logic [ecl_pkg::QPTR_W:0]       cnt;

  assign stat.full  = (cnt == (ecl_pkg::QPTR_W + 1)'(ecl_pkg::QDEPTH));
  assign stat.empty = (cnt == '0);
  assign rd_data    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == ecl_pkg::QPTR_W'(ecl_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == ecl_pkg::QPTR_W'(ecl_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== src/ecl_back.sv =====
module ecl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ecl_pkg::q_status_t    stat,
  input  ecl_pkg::q_entry_t     entry,
  output logic                  pop,
  ecl_out_if.source             out_item
);

  logic [ecl_pkg::TOTAL_W-1:0]  gamma_total;
  logic [ecl_pkg::TOTAL_W-1:0]  delta_total;
  logic [ecl_pkg::TOTAL_W-1:0]  omega_total;
  logic [ecl_pkg::COUNT_W-1:0]  item_count;
  logic [ecl_pkg::TOTAL_W-1:0]  gamma_next;
  logic [ecl_pkg::TOTAL_W-1:0]  delta_next;
  logic [ecl_pkg::TOTAL_W-1:0]  omega_next;
  logic [ecl_pkg::COUNT_W-1:0]  item_count_next;
  logic                         out_valid;

  function automatic logic [ecl_pkg::TOTAL_W-1:0] sat_add(
    input logic [ecl_pkg::TOTAL_W-1:0] a,
    input logic [ecl_pkg::CODE_W-1:0]  b
  );
    logic [ecl_pkg::TOTAL_W:0] s;
    s = {1'b0, a} + (ecl_pkg::TOTAL_W + 1)'(b);
    return s[ecl_pkg::TOTAL_W] ? ecl_pkg::TOTAL_MAX : s[ecl_pkg::TOTAL_W-1:0];
  endfunction

  assign out_item.valid = out_valid;
  assign pop = !stat.empty && (!entry.last || !out_valid || out_item.ready);

  always_comb begin
    gamma_next      = sat_add(gamma_total, ecl_pkg::gamma_len(entry.blen));
    delta_next      = sat_add(delta_total, ecl_pkg::delta_len(entry.blen));
    omega_next      = sat_add(omega_total, ecl_pkg::omega_len(entry.blen));
    item_count_next = (item_count == ecl_pkg::COUNT_MAX) ? item_count
                                                          : item_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_total <= '0;
      delta_total <= '0;
      omega_total <= '0;
      item_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_item.ready) out_valid <= 1'b0;
      if (pop) begin
        if (entry.last) begin
          out_valid   <= 1'b1;
          gamma_total <= '0;
          delta_total <= '0;
          omega_total <= '0;
          item_count  <= '0;
        end else begin
          gamma_total <= gamma_next;
          delta_total <= delta_next;
          omega_total <= omega_next;
          item_count  <= item_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      out_item.gamma_bits  <= gamma_next;
      out_item.delta_bits  <= delta_next;
      out_item.omega_bits  <= omega_next;
      out_item.value_count <= item_count_next;
    end
  end

endmodule

// ===== src/elias_code_length_totals.sv =====
// channel    dir  payload                                           handshake
// in_item    in   value[31:0], last                                 valid/ready
// out_item   out  gamma_bits, delta_bits, omega_bits, value_count   valid/ready
//
// One item per cycle sustained while no held result stalls the back end; a result passes
// through classify, the two-entry queue and the output register before it is valid.
// Synchronous active-high rst clears totals, count, queue and output valid.
// A held result stalls the back end only on the next last item; the queue then
// fills and in_item.ready drops.
module elias_code_length_totals (
  input  logic        clk,
  input  logic        rst,
  ecl_in_if.sink      in_item,
  ecl_out_if.source   out_item
);

  ecl_pkg::q_status_t  q_stat;
  ecl_pkg::q_entry_t   q_wr;
  ecl_pkg::q_entry_t   q_rd;
  logic                q_push;
  logic                q_pop;

  ecl_front u_front (
    .in_item (in_item),
    .stat    (q_stat),
    .push    (q_push),
    .entry   (q_wr)
  );

  ecl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  ecl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (q_stat),
    .entry    (q_rd),
    .pop      (q_pop),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_gamma_ge_count: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.gamma_bits >= 64'(out_item.value_count)))
    else $error("gamma total below item count");

  a_omega_ge_count: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.omega_bits >= 64'(out_item.value_count)))
    else $error("omega total below item count");
`endif

endmodule
